// ===== design/cra_pkg.sv =====
package cra_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int CFG_ADDR_WIDTH = 1;
  localparam int RANGE_MIN_RST  = 0;
  localparam int RANGE_MAX_RST  = 360;

  typedef logic [2:0] op_t;

  localparam op_t OP_ADD   = 3'd0;
  localparam op_t OP_SUB   = 3'd1;
  localparam op_t OP_MUL   = 3'd2;
  localparam op_t OP_DIV   = 3'd3;
  localparam op_t OP_DIST  = 3'd4;
  localparam op_t OP_SDIFF = 3'd5;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RANGE_MIN = 1'b0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RANGE_MAX = 1'b1;

  typedef struct packed {
    logic vld;
    op_t  op;
    logic err;
  } ctl_t;

endpackage

// ===== design/circular_range_alu.sv =====
// Circular range ALU.
// Items enter on the in_ channel (valid/ready) with an opcode and two signed
// operands; each item gives exactly one transfer on the out_ channel with its
// error flag and result, in [range_min, range_max) for OP_ADD to OP_DIST.
// The user must write the two range registers through the cfg_ port only while no
// item is in flight; the block does not enforce this. An empty or negative range,
// or a divide by zero, gives zero with the error flag set.
// The pipeline has one input stage, one operand stage, DATA_WIDTH divider stages
// (one quotient bit per stage), three stages that select the quotient and form
// the offset and its magnitude, 2*DATA_WIDTH + 1 modulo stages (a load stage,
// then one remainder bit per stage) and two output stages.
// Throughput is one item per cycle while the skid register is empty. When the
// receiver stalls, the finished result moves into a skid register, which freezes
// the pipeline and drops in_ready until that result is taken. Reset clears all
// valid bits and loads range_min with 0 and range_max with 360.
module circular_range_alu #(
  parameter int DATA_WIDTH = cra_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic signed [DATA_WIDTH-1:0]        in_left_operand,
  input  logic signed [DATA_WIDTH-1:0]        in_right_operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cra_pkg::OUT_WIDTH-1:0] out_wrapped_result,
  output logic                                out_error_flag,
  input  logic                                cfg_wen,
  input  logic [cra_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [DATA_WIDTH-1:0]               cfg_wdata
);

  localparam int W  = DATA_WIDTH;
  localparam int MW = 2 * DATA_WIDTH;
  localparam int OW = cra_pkg::OUT_WIDTH;

  logic [W-1:0] range_min_r, range_max_r;
  logic signed [W:0] span_s;
  logic [W-1:0] span;
  logic range_bad;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= W'(cra_pkg::RANGE_MIN_RST);
      range_max_r <= W'(cra_pkg::RANGE_MAX_RST);
    end else if (cfg_wen) begin
      case (cfg_addr)
        cra_pkg::REG_RANGE_MIN: range_min_r <= cfg_wdata;
        cra_pkg::REG_RANGE_MAX: range_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] lo_s;
  assign lo_s      = $signed(range_min_r);
  assign span_s    = $signed({range_max_r[W-1], range_max_r})
                   - $signed({range_min_r[W-1], range_min_r});
  assign span      = span_s[W-1:0];
  assign range_bad = (span_s <= 0);

  // Input stage.
  cra_pkg::ctl_t ctl0_r;
  logic signed [W-1:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r <= '{vld: in_valid, op: in_opcode, err: range_bad};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= in_left_operand;
      b0_r <= in_right_operand;
    end
  end

  // Operand stage.
  logic signed [W:0]    sum_s, dif_s, ndif_s;
  logic signed [MW-1:0] prod_s, xp_nxt, xq_nxt;
  logic [W:0]           aabs_w, babs_w;
  logic                 dz;

  always_comb begin
    sum_s  = $signed({a0_r[W-1], a0_r}) + $signed({b0_r[W-1], b0_r});
    dif_s  = $signed({a0_r[W-1], a0_r}) - $signed({b0_r[W-1], b0_r});
    ndif_s = $signed({b0_r[W-1], b0_r}) - $signed({a0_r[W-1], a0_r});
    prod_s = a0_r * b0_r;
    aabs_w = a0_r[W-1] ? -{a0_r[W-1], a0_r} : {a0_r[W-1], a0_r};
    babs_w = b0_r[W-1] ? -{b0_r[W-1], b0_r} : {b0_r[W-1], b0_r};
    dz     = (b0_r == '0) && (ctl0_r.op == cra_pkg::OP_DIV);
    xq_nxt = MW'(dif_s);
    case (ctl0_r.op)
      cra_pkg::OP_ADD:   xp_nxt = MW'(sum_s);
      cra_pkg::OP_SUB:   xp_nxt = MW'(dif_s);
      cra_pkg::OP_MUL:   xp_nxt = prod_s;
      cra_pkg::OP_DIST,
      cra_pkg::OP_SDIFF: xp_nxt = MW'(ndif_s);
      default:           xp_nxt = '0;
    endcase
  end

  // Divider pipeline: index 0 is loaded by the operand stage.
  cra_pkg::ctl_t        dctl_r [W+1];
  logic [W-1:0]         drem_r [W+1];
  logic [W-1:0]         ddv_r  [W+1];
  logic [W-1:0]         dvs_r  [W+1];
  logic                 dneg_r [W+1];
  logic signed [MW-1:0] dxp_r  [W+1];
  logic signed [MW-1:0] dxq_r  [W+1];

  logic [W-1:0] drem_nxt [W];
  logic [W-1:0] ddv_nxt  [W];

  always_comb begin
    logic [W:0] sh;
    logic       ge;
    for (int k = 0; k < W; k++) begin
      sh = {drem_r[k], ddv_r[k][W-1]};
      ge = (sh >= {1'b0, dvs_r[k]});
      drem_nxt[k] = ge ? W'(sh - {1'b0, dvs_r[k]}) : W'(sh);
      ddv_nxt[k]  = {ddv_r[k][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= W; k++) dctl_r[k] <= '0;
    end else if (en) begin
      dctl_r[0] <= '{vld: ctl0_r.vld, op: ctl0_r.op, err: ctl0_r.err | dz};
      for (int k = 0; k < W; k++) dctl_r[k+1] <= dctl_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0] <= '0;
      ddv_r[0]  <= aabs_w[W-1:0];
      dvs_r[0]  <= babs_w[W-1:0];
      dneg_r[0] <= a0_r[W-1] ^ b0_r[W-1];
      dxp_r[0]  <= xp_nxt;
      dxq_r[0]  <= xq_nxt;
      for (int k = 0; k < W; k++) begin
        drem_r[k+1] <= drem_nxt[k];
        ddv_r[k+1]  <= ddv_nxt[k];
        dvs_r[k+1]  <= dvs_r[k];
        dneg_r[k+1] <= dneg_r[k];
        dxp_r[k+1]  <= dxp_r[k];
        dxq_r[k+1]  <= dxq_r[k];
      end
    end
  end

  // Quotient sign and operand selection.
  cra_pkg::ctl_t        qctl_r;
  logic signed [MW-1:0] qxp_r, qxq_r;
  logic signed [W:0]    quo_s;

  assign quo_s = dneg_r[W] ? -$signed({1'b0, ddv_r[W]}) : $signed({1'b0, ddv_r[W]});

  always_ff @(posedge clk) begin
    if (!rst_n) qctl_r <= '0;
    else if (en) qctl_r <= dctl_r[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qxp_r <= (dctl_r[W].op == cra_pkg::OP_DIV) ? MW'(quo_s) : dxp_r[W];
      qxq_r <= dxq_r[W];
    end
  end

  // Offset from range_min.
  cra_pkg::ctl_t        tctl_r;
  logic signed [MW:0]   tp_r, tq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tctl_r <= '0;
    else if (en) tctl_r <= qctl_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r <= $signed({qxp_r[MW-1], qxp_r}) - (MW+1)'(lo_s);
      tq_r <= $signed({qxq_r[MW-1], qxq_r}) - (MW+1)'(lo_s);
    end
  end

  // Magnitude and sign of the offsets.
  cra_pkg::ctl_t mctl_r;
  logic [MW-1:0] pmag_r, qmag_r;
  logic          pneg_r, qneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mctl_r <= '0;
    else if (en) mctl_r <= tctl_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pneg_r <= tp_r[MW];
      qneg_r <= tq_r[MW];
      pmag_r <= tp_r[MW] ? MW'(-tp_r) : MW'(tp_r);
      qmag_r <= tq_r[MW] ? MW'(-tq_r) : MW'(tq_r);
    end
  end

  // Modulo pipeline, two lanes, index 0 loaded from the magnitude stage.
  cra_pkg::ctl_t mmctl_r [MW+1];
  logic [W-1:0]  prem_r  [MW+1];
  logic [W-1:0]  qrem_r  [MW+1];
  logic [MW-1:0] pdv_r   [MW+1];
  logic [MW-1:0] qdv_r   [MW+1];
  logic          mpn_r   [MW+1];
  logic          mqn_r   [MW+1];

  logic [W-1:0]  prem_nxt [MW];
  logic [W-1:0]  qrem_nxt [MW];

  always_comb begin
    logic [W:0] shp, shq;
    for (int k = 0; k < MW; k++) begin
      shp = {prem_r[k], pdv_r[k][MW-1]};
      shq = {qrem_r[k], qdv_r[k][MW-1]};
      prem_nxt[k] = (shp >= {1'b0, span}) ? W'(shp - {1'b0, span}) : W'(shp);
      qrem_nxt[k] = (shq >= {1'b0, span}) ? W'(shq - {1'b0, span}) : W'(shq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= MW; k++) mmctl_r[k] <= '0;
    end else if (en) begin
      mmctl_r[0] <= mctl_r;
      for (int k = 0; k < MW; k++) mmctl_r[k+1] <= mmctl_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prem_r[0] <= '0;
      qrem_r[0] <= '0;
      pdv_r[0]  <= pmag_r;
      qdv_r[0]  <= qmag_r;
      mpn_r[0]  <= pneg_r;
      mqn_r[0]  <= qneg_r;
      for (int k = 0; k < MW; k++) begin
        prem_r[k+1] <= prem_nxt[k];
        qrem_r[k+1] <= qrem_nxt[k];
        pdv_r[k+1]  <= {pdv_r[k][MW-2:0], 1'b0};
        qdv_r[k+1]  <= {qdv_r[k][MW-2:0], 1'b0};
        mpn_r[k+1]  <= mpn_r[k];
        mqn_r[k+1]  <= mqn_r[k];
      end
    end
  end

  // Floor correction and shift back by range_min.
  cra_pkg::ctl_t       fctl_r;
  logic signed [W-1:0] p_r, q_r;
  logic [W-1:0]        pm, qm;

  always_comb begin
    pm = (mpn_r[MW] && prem_r[MW] != '0) ? span - prem_r[MW] : prem_r[MW];
    qm = (mqn_r[MW] && qrem_r[MW] != '0) ? span - qrem_r[MW] : qrem_r[MW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fctl_r <= '0;
    else if (en) fctl_r <= mmctl_r[MW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed(pm + range_min_r);
      q_r <= $signed(qm + range_min_r);
    end
  end

  // Result selection.
  logic                fv_r, ferr_r;
  logic signed [OW-1:0] fres_r;
  logic signed [W-1:0]  sel;
  logic signed [W:0]    negq;

  always_comb begin
    negq = -$signed({q_r[W-1], q_r});
    case (fctl_r.op)
      cra_pkg::OP_ADD,
      cra_pkg::OP_SUB,
      cra_pkg::OP_MUL,
      cra_pkg::OP_DIV:   sel = p_r;
      cra_pkg::OP_DIST:  sel = (p_r < q_r) ? p_r : q_r;
      cra_pkg::OP_SDIFF: begin
        if (q_r > p_r) sel = p_r;
        else if (negq[W] != negq[W-1]) sel = {1'b0, {(W-1){1'b1}}};
        else sel = negq[W-1:0];
      end
      default:           sel = '0;
    endcase
    if (fctl_r.err) sel = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else if (en) fv_r <= fctl_r.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fres_r <= OW'(sel);
      ferr_r <= fctl_r.err;
    end
  end

  // Skid register on the output.
  logic                 skid_v_r, skid_err_r;
  logic signed [OW-1:0] skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) skid_v_r <= 1'b0;
    end else if (fv_r && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && fv_r && !out_ready) begin
      skid_res_r <= fres_r;
      skid_err_r <= ferr_r;
    end
  end

  assign en                 = !skid_v_r;
  assign in_ready           = en;
  assign out_valid          = skid_v_r | fv_r;
  assign out_wrapped_result = skid_v_r ? skid_res_r : fres_r;
  assign out_error_flag     = skid_v_r ? skid_err_r : ferr_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_wrapped_result == '0)
    else $error("error result is not zero");

  a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_ready)
    else $error("input accepted while skid register is full");

  a_skid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(fv_r) && !$past(out_ready))
    else $error("skid register loaded without a stalled result");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int DW = 32;
  localparam int LATENCY = 3 * DW + 8;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_opcode;
  logic signed [DW-1:0] in_left_operand;
  logic signed [DW-1:0] in_right_operand;
  logic out_valid;
  logic out_ready;
  logic signed [cra_pkg::OUT_WIDTH-1:0] out_wrapped_result;
  logic out_error_flag;
  logic cfg_wen;
  logic [cra_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [DW-1:0] cfg_wdata;

  typedef struct {
    logic signed [31:0] value;
    logic err;
  } wrap_result_t;

  wrap_result_t wrap_results_due[$];
  logic signed [DW-1:0] range_lo;
  logic signed [DW-1:0] range_hi;
  int failures;
  longint cycles;
  bit quiet_in;
  bit quiet_out;

  circular_range_alu #(.DATA_WIDTH(DW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_left_operand(in_left_operand), .in_right_operand(in_right_operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_wrapped_result(out_wrapped_result), .out_error_flag(out_error_flag),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint floor_wrap(longint x, longint lo, longint span);
    longint m;
    m = (x - lo) % span;
    if (m < 0) m += span;
    return m + lo;
  endfunction

  function automatic wrap_result_t compute_wrap(cra_pkg::op_t op,
                                                logic signed [DW-1:0] a_in,
                                                logic signed [DW-1:0] b_in);
    wrap_result_t r;
    longint a, b, lo, span, p, q, v;
    a = a_in;
    b = b_in;
    lo = range_lo;
    span = longint'(range_hi) - lo;
    v = 0;
    r.err = 1'b0;
    if (span <= 0) begin
      r.err = 1'b1;
    end else begin
      p = floor_wrap(b - a, lo, span);
      q = floor_wrap(a - b, lo, span);
      case (op)
        cra_pkg::OP_ADD: v = floor_wrap(a + b, lo, span);
        cra_pkg::OP_SUB: v = floor_wrap(a - b, lo, span);
        cra_pkg::OP_MUL: v = floor_wrap(a * b, lo, span);
        cra_pkg::OP_DIV: begin
          if (b == 0) r.err = 1'b1;
          else v = floor_wrap(a / b, lo, span);
        end
        cra_pkg::OP_DIST: v = (p < q) ? p : q;
        cra_pkg::OP_SDIFF: begin
          if (q > p) v = p;
          else begin
            v = -q;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
          end
        end
        default: v = 0;
      endcase
    end
    r.value = v[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet_out) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    wrap_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (wrap_results_due.size() == 0) begin
        $display("%0t unexpected transfer: actual %0d err %0b", $time,
                 out_wrapped_result, out_error_flag);
        failures++;
      end else begin
        exp_r = wrap_results_due.pop_front();
        if (out_wrapped_result !== exp_r.value) begin
          $display("%0t result mismatch: expected %0d actual %0d", $time,
                   exp_r.value, out_wrapped_result);
          failures++;
        end
        if (out_error_flag !== exp_r.err) begin
          $display("%0t error flag mismatch: expected %0b actual %0b", $time,
                   exp_r.err, out_error_flag);
          failures++;
        end
      end
    end
  end

  task automatic send_item(cra_pkg::op_t op, logic signed [DW-1:0] a,
                           logic signed [DW-1:0] b);
    if (!quiet_in) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_left_operand <= a;
    in_right_operand <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    wrap_results_due.push_back(compute_wrap(op, a, b));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (wrap_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_range(logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
    drain();
    cfg_wen <= 1'b1;
    cfg_addr <= cra_pkg::REG_RANGE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr <= cra_pkg::REG_RANGE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wen <= 1'b0;
    range_lo = lo;
    range_hi = hi;
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(800)) - 400);
      3: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_range;
    cra_pkg::op_t op;
    for (int i = 0; i < 6; i++) begin
      op = cra_pkg::op_t'(i);
      send_item(op, 32'h7fff_ffff, 32'h8000_0000);
    end
    send_item(cra_pkg::OP_ADD, 350, 20);
    send_item(cra_pkg::OP_SUB, 10, 20);
    send_item(cra_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_item(cra_pkg::OP_DIV, 100, 0);
    send_item(cra_pkg::OP_DIV, 32'h8000_0000, -1);
    send_item(cra_pkg::OP_DIST, 10, 350);
    send_item(cra_pkg::OP_SDIFF, 10, 350);
    send_item(cra_pkg::OP_SDIFF, 350, 10);
    send_item(cra_pkg::OP_SDIFF, 0, 180);
    send_item(3'd6, 5, 5);
    send_item(3'd7, -5, 5);
  endtask

  task automatic test_range_extremes;
    write_range(32'h8000_0000, 32'h7fff_ffff);
    send_item(cra_pkg::OP_SDIFF, 32'h8000_0000, 32'h7fff_fffe);
    send_item(cra_pkg::OP_SDIFF, 0, 0);
    send_item(cra_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(cra_pkg::OP_ADD, 32'h7fff_ffff, 1);
    write_range(5, 5);
    send_item(cra_pkg::OP_ADD, 1, 2);
    send_item(cra_pkg::OP_DIV, 1, 0);
    write_range(10, -10);
    send_item(cra_pkg::OP_DIST, 1, 2);
    write_range(32'h7fff_fffe, 32'h7fff_ffff);
    send_item(cra_pkg::OP_SUB, 32'h8000_0000, 3);
  endtask

  task automatic test_random_items;
    logic signed [DW-1:0] lo, hi;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 4)
        0: begin lo = int'($urandom_range(400)) - 200; hi = lo + $urandom_range(1, 400); end
        1: begin lo = $urandom; hi = $urandom; end
        2: begin lo = -180; hi = 180; end
        default: begin lo = 32'h8000_0000 + $urandom_range(3); hi = 32'h7fff_ffff; end
      endcase
      write_range(lo, hi);
      quiet_in = (phase == 4);
      quiet_out = (phase == 4);
      for (int i = 0; i < 150; i++)
        send_item(cra_pkg::op_t'($urandom_range(7)), pick_operand(), pick_operand());
      quiet_in = 0;
      quiet_out = 0;
    end
    write_range(0, 360);
  endtask

  initial begin
    failures = 0;
    cycles = 0;
    quiet_in = 0;
    quiet_out = 0;
    range_lo = cra_pkg::RANGE_MIN_RST;
    range_hi = cra_pkg::RANGE_MAX_RST;
    rst_n = 0;
    in_valid = 0;
    in_opcode = 0;
    in_left_operand = 0;
    in_right_operand = 0;
    out_ready = 0;
    cfg_wen = 0;
    cfg_addr = 0;
    cfg_wdata = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_range();
    test_range_extremes();
    test_random_items();
    drain();
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
